@@ hw/rtl/ntc_pkg.sv @@
// ntc_pkg: shared types, constants and the natural log table for the ntc core
// no dependencies

package ntc_pkg;

	localparam int AVG_SAMPLES     = 16;
	localparam int DISCARD_SAMPLES = 2;
	localparam int SAMPLE_BITS     = 12;
	localparam int LN_TABLE_DEPTH  = 64;
	localparam int LN_IDX_W        = $clog2(LN_TABLE_DEPTH);
	localparam int CNT_W           = $clog2(DISCARD_SAMPLES + AVG_SAMPLES + 1);
	localparam int SUM_W           = SAMPLE_BITS + $clog2(AVG_SAMPLES) + 1;
	localparam int CFG_IDX_W       = 3;
	localparam int TEMP_W          = 16;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam int KELVIN_CENTI     = 27315;
	localparam int FAULT_TEMP_CENTI = -10000;
	localparam int TEMP_MAX_CENTI   = 32767;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_SCALE = 3'd0,
		REG_SERIES_RES = 3'd1,
		REG_NOMINAL_RES = 3'd2,
		REG_BETA       = 3'd3,
		REG_NOMINAL_T  = 3'd4,
		REG_FAULT_THR  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LN_NUM,
		ST_LN_DEN,
		ST_L16,
		ST_MUL_D,
		ST_CHECK,
		ST_DIV,
		ST_FINISH,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture sum and start evaluation
		logic ln_start;  // start log of operand
		logic ln_sel;    // 0 numerator, 1 denominator
		logic mk_l16;
		logic mk_d;
		logic div_start;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ln_done;
		logic div_done;
		logic early;     // result already known (fault or special case)
		logic d_bad;     // D <= 0
	} dp_sts_t;

	// ln(1 + i/depth) in Q16 for every entry, from 2*atanh(i / (2*depth + i))
	function automatic logic [LN_TABLE_DEPTH*16-1:0] ln_table_build();
		logic [LN_TABLE_DEPTH*16-1:0] t;
		logic [63:0] z, z2, term, acc, r;
		t = '0;
		for (int i = 0; i < LN_TABLE_DEPTH; i++) begin
			z = (64'(i) << 32) / 64'(2 * LN_TABLE_DEPTH + i);
			z2 = (z * z) >> 32;
			term = z;
			acc = '0;
			for (int j = 1; j < 60 && term != 64'd0; j += 2) begin
				acc = acc + term / 64'(j);
				term = (term * z2) >> 32;
			end
			r = (64'd2 * acc + 64'd32768) >> 16;
			t[i*16 +: 16] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
		end
		return t;
	endfunction

	localparam logic [LN_TABLE_DEPTH*16-1:0] LN_TABLE = ln_table_build();

	// ln(1 + i/64) in Q16
	function automatic logic [15:0] ln_rom(input logic [LN_IDX_W-1:0] i);
		return LN_TABLE[32'(i)*16 +: 16];
	endfunction

endpackage

@@ hw/rtl/ntc_if.sv @@
// ntc_if: valid/ready channel interfaces for samples, results and config writes
// depends on ntc_pkg

interface ntc_in_if;
	logic valid;
	logic ready;
	logic [ntc_pkg::SAMPLE_BITS-1:0] sample;
	logic start_conversion;
	modport source (output valid, sample, start_conversion, input ready);
	modport sink (input valid, sample, start_conversion, output ready);
endinterface

interface ntc_out_if;
	logic valid;
	logic ready;
	logic signed [ntc_pkg::TEMP_W-1:0] temperature_centi_c;
	logic sensor_fault;
	modport source (output valid, temperature_centi_c, sensor_fault, input ready);
	modport sink (input valid, temperature_centi_c, sensor_fault, output ready);
endinterface

interface ntc_cfg_if;
	logic valid;
	logic ready;
	logic [ntc_pkg::CFG_IDX_W-1:0] index;
	logic [19:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ntc_ctrl.sv @@
// ntc_ctrl: sequencer for the evaluation after the last averaged sample
// depends on ntc_pkg

module ntc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic                out_taken,
	input  ntc_pkg::dp_sts_t    sts,
	output ntc_pkg::dp_cmd_t    cmd,
	output logic                busy,
	output logic                out_valid
);

	ntc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ntc_pkg::ST_IDLE);
		out_valid = 1'b0;
		case (state_q)
			ntc_pkg::ST_IDLE: begin
				if (go) begin
					cmd.load = 1'b1;
					state_d = ntc_pkg::ST_CHECK;
				end
			end
			ntc_pkg::ST_CHECK: begin
				if (sts.early) begin
					state_d = ntc_pkg::ST_OUT;
				end else begin
					cmd.ln_start = 1'b1;
					state_d = ntc_pkg::ST_LN_NUM;
				end
			end
			ntc_pkg::ST_LN_NUM: begin
				if (sts.ln_done) begin
					cmd.ln_start = 1'b1;
					cmd.ln_sel = 1'b1;
					state_d = ntc_pkg::ST_LN_DEN;
				end
			end
			ntc_pkg::ST_LN_DEN: begin
				cmd.ln_sel = 1'b1;
				if (sts.ln_done) begin
					state_d = ntc_pkg::ST_L16;
				end
			end
			ntc_pkg::ST_L16: begin
				cmd.mk_l16 = 1'b1;
				state_d = ntc_pkg::ST_MUL_D;
			end
			ntc_pkg::ST_MUL_D: begin
				cmd.mk_d = 1'b1;
				state_d = ntc_pkg::ST_DIV;
			end
			ntc_pkg::ST_DIV: begin
				if (sts.d_bad) begin
					cmd.finish = 1'b1;
					state_d = ntc_pkg::ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ntc_pkg::ST_FINISH;
				end
			end
			ntc_pkg::ST_FINISH: begin
				if (sts.div_done) begin
					cmd.finish = 1'b1;
					state_d = ntc_pkg::ST_OUT;
				end
			end
			ntc_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_taken) begin
					state_d = ntc_pkg::ST_IDLE;
				end
			end
			default: state_d = ntc_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/ntc_dp.sv @@
// ntc_dp: fixed-point datapath (ratio, table log, beta equation, divider)
// depends on ntc_pkg

module ntc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ntc_pkg::dp_cmd_t                  cmd,
	input  logic [ntc_pkg::SUM_W-1:0]         sum,
	input  logic [15:0]                       full_scale,
	input  logic [19:0]                       series_res,
	input  logic [19:0]                       nominal_res,
	input  logic [13:0]                       beta,
	input  logic signed [8:0]                 nominal_t,
	input  logic [11:0]                       fault_thr,
	output ntc_pkg::dp_sts_t                  sts,
	output logic signed [ntc_pkg::TEMP_W-1:0] temp,
	output logic                              fault
);

	localparam int AVG_LOG = $clog2(ntc_pkg::AVG_SAMPLES);
	localparam int TOT_W = 16 + AVG_LOG + 1;
	localparam int OPW = 20 + TOT_W;
	localparam int KW = $clog2(OPW);

	logic [TOT_W-1:0] avg_total, thr_total;
	logic [OPW-1:0]   num_q, den_q;
	logic [TOT_W-1:0] diff;
	logic signed [ntc_pkg::TEMP_W-1:0] temp_q;
	logic fault_q, early_q;

	assign avg_total = TOT_W'(full_scale) << AVG_LOG;
	assign thr_total = TOT_W'(fault_thr) << AVG_LOG;
	assign diff = avg_total - TOT_W'(sum);

	// log unit: normalize one bit per cycle, then table lookup and interpolate
	logic [OPW-1:0] ln_x_q;
	logic [KW-1:0]  ln_k_q;
	logic [1:0]     ln_ph_q;
	logic           ln_busy_q, ln_done_q;
	logic           ln_which_q;
	logic [39:0]    ln_res_q;
	logic signed [40:0] l32_q;
	logic [31:0]    frac;
	logic [ntc_pkg::LN_IDX_W-1:0] idx;
	logic [31-ntc_pkg::LN_IDX_W:0] rem;
	logic [15:0] lo, hi;
	logic [16+32-ntc_pkg::LN_IDX_W:0] slope;

	// fraction after the leading one, mantissa left-aligned to OPW-1
	assign frac = OPW > 33 ? ln_x_q[OPW-2 -: 32] : 32'(ln_x_q[OPW-2:0]) << (33 - OPW);
	assign idx = frac[31 -: ntc_pkg::LN_IDX_W];
	assign rem = frac[31-ntc_pkg::LN_IDX_W:0];
	assign lo = ntc_pkg::ln_rom(idx);
	assign hi = (idx == ntc_pkg::LN_IDX_W'(ntc_pkg::LN_TABLE_DEPTH - 1)) ? ntc_pkg::LN2_Q16
		: ntc_pkg::ln_rom(idx + 1'b1);

	logic [15:0] dlt_s1;
	logic [31-ntc_pkg::LN_IDX_W:0] rem_s1;
	logic [15:0] lo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ln_busy_q <= 1'b0;
			ln_done_q <= 1'b0;
			ln_ph_q <= '0;
		end else begin
			ln_done_q <= 1'b0;
			if (cmd.ln_start) begin
				ln_busy_q <= 1'b1;
				ln_ph_q <= 2'd0;
			end else if (ln_busy_q) begin
				case (ln_ph_q)
					2'd0: begin
						if (ln_x_q[OPW-1]) begin
							ln_ph_q <= 2'd1;
						end
					end
					2'd1: ln_ph_q <= 2'd2;
					2'd2: ln_ph_q <= 2'd3;
					default: begin
						ln_busy_q <= 1'b0;
						ln_done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ln_start) begin
			ln_x_q <= cmd.ln_sel ? den_q : num_q;
			ln_k_q <= KW'(OPW - 1);
			ln_which_q <= cmd.ln_sel;
		end else if (ln_busy_q) begin
			case (ln_ph_q)
				2'd0: begin
					if (!ln_x_q[OPW-1]) begin
						ln_x_q <= ln_x_q << 1;
						ln_k_q <= ln_k_q - 1'b1;
					end
				end
				2'd1: begin
					lo_s1 <= lo;
					dlt_s1 <= (hi < lo) ? 16'd0 : hi - lo;
					rem_s1 <= rem;
				end
				2'd2: slope <= dlt_s1 * rem_s1;
				default: begin
					ln_res_q <= 40'(ln_k_q) * 40'(ntc_pkg::LN2_Q32) + (40'(lo_s1) << 16)
						+ 40'(slope >> (16 - ntc_pkg::LN_IDX_W));
				end
			endcase
		end
		// the operand that just finished decides between capture and subtract
		if (ln_done_q && !ln_which_q) begin
			l32_q <= 41'(ln_res_q);
		end else if (ln_done_q) begin
			l32_q <= l32_q - 41'(ln_res_q);
		end
	end

	// beta equation
	logic signed [22:0] l16_q;
	logic signed [16:0] t0c;
	logic signed [40:0] d_q;
	logic [40:0] beta_term_q;
	logic signed [40:0] prod_q;
	logic [40:0] uabs;

	assign t0c = 17'(nominal_t) * 17'sd100 + 17'sd27315;
	assign uabs = l32_q[40] ? 41'(-l32_q) : 41'(l32_q);

	always_ff @(posedge clk) begin
		if (cmd.mk_l16) begin
			l16_q <= l32_q[40] ? -23'((uabs + 41'd32768) >> 16) : 23'((uabs + 41'd32768) >> 16);
			beta_term_q <= 41'(beta) * 41'd6553600;
		end
		if (cmd.mk_d) begin
			d_q <= $signed(beta_term_q) + 41'(t0c) * 41'(l16_q);
		end
	end

	// restoring divider, one quotient bit per cycle
	localparam int NW = 56;
	logic [NW-1:0] dnum_q, quo_q;
	logic [40:0]   rem_q;
	logic [5:0]    dcnt_q;
	logic          dbusy_q, ddone_q;
	logic [41:0]   trial;
	logic [NW-1:0] n_calc;

	assign n_calc = NW'(beta_term_q) * NW'(t0c) + NW'(d_q >>> 1);
	assign trial = {rem_q, dnum_q[NW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dcnt_q <= 6'(NW);
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == 6'd1) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dnum_q <= n_calc;
			rem_q <= '0;
			quo_q <= '0;
		end else if (dbusy_q) begin
			dnum_q <= dnum_q << 1;
			if (!trial[41]) begin
				rem_q <= trial[40:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[39:0], dnum_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	logic signed [NW:0] tout;
	assign tout = $signed({1'b0, quo_q}) - (NW+1)'(ntc_pkg::KELVIN_CENTI);

	// load, early exits and finish
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= OPW'(series_res) * OPW'(sum);
			den_q <= OPW'(nominal_res) * OPW'(diff);
			if (TOT_W'(sum) < thr_total || TOT_W'(sum) >= avg_total) begin
				fault_q <= 1'b1;
				early_q <= 1'b1;
				temp_q <= ntc_pkg::TEMP_W'(ntc_pkg::FAULT_TEMP_CENTI);
			end else begin
				fault_q <= 1'b0;
				early_q <= (sum == '0) || (series_res == '0) || (nominal_res == '0) || (beta == '0);
				temp_q <= ntc_pkg::TEMP_W'(-ntc_pkg::KELVIN_CENTI);
			end
		end
		if (cmd.finish) begin
			if (d_q < 0) begin
				temp_q <= ntc_pkg::TEMP_W'(-ntc_pkg::KELVIN_CENTI);
			end else if (d_q == 0 || tout > (NW+1)'(ntc_pkg::TEMP_MAX_CENTI)) begin
				temp_q <= ntc_pkg::TEMP_W'(ntc_pkg::TEMP_MAX_CENTI);
			end else begin
				temp_q <= tout[ntc_pkg::TEMP_W-1:0];
			end
		end
	end

	assign sts.ln_done = ln_done_q;
	assign sts.div_done = ddone_q;
	assign sts.early = early_q;
	assign sts.d_bad = (d_q <= 0);
	assign temp = temp_q;
	assign fault = fault_q;

endmodule

@@ hw/rtl/ntc_thermistor_temperature_core.sv @@
// ntc_thermistor_temperature_core: top level of the ntc thermistor converter
// depends on ntc_pkg, ntc_if, ntc_ctrl, ntc_dp
//
// usage
//   in channel: one adc sample per transfer; start_conversion marks the first
//   sample of a conversion; the first two are dropped, sixteen are summed
//   out channel: one result per finished conversion, temperature in
//   hundredths of degree c, sensor_fault with -10000 on a fault
//   cfg channel: register writes by index, taken at any time, meant only
//   while idle
// sequence
//   samples are accepted back to back while the core is not busy; after
//   the last sample the result passes two log units (one normalization bit
//   per cycle) and a restoring divide, which is skipped when D is not
//   positive; fault and special-case results (zero ratio, resistance or
//   beta) go from the check state straight to the output state
// reset
//   arst_n clears the sequencer and sample counter; config registers
//   return to defaults; no clearing pass is needed, the log table is constant logic
// stall
//   a result waits in the output register until taken; no new sample is
//   taken while the evaluation or the held result are pending

module ntc_thermistor_temperature_core (
	input  logic            clk,
	input  logic            arst_n,
	ntc_in_if.sink          in_ch,
	ntc_out_if.source       out_ch,
	ntc_cfg_if.sink         cfg
);

	// configuration registers
	logic [15:0] full_scale_q;
	logic [19:0] series_res_q, nominal_res_q;
	logic [13:0] beta_q;
	logic signed [8:0] nominal_t_q;
	logic [11:0] fault_thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= 16'd1000;
			series_res_q <= 20'd10000;
			nominal_res_q <= 20'd10000;
			beta_q <= 14'd3950;
			nominal_t_q <= 9'sd25;
			fault_thr_q <= 12'd5;
		end else if (cfg.valid) begin
			case (cfg.index)
				ntc_pkg::REG_FULL_SCALE: full_scale_q <= cfg.data[15:0];
				ntc_pkg::REG_SERIES_RES: series_res_q <= cfg.data;
				ntc_pkg::REG_NOMINAL_RES: nominal_res_q <= cfg.data;
				ntc_pkg::REG_BETA: beta_q <= cfg.data[13:0];
				ntc_pkg::REG_NOMINAL_T: nominal_t_q <= cfg.data[8:0];
				ntc_pkg::REG_FAULT_THR: fault_thr_q <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// sample accumulation
	logic [ntc_pkg::CNT_W-1:0] count_q;
	logic                      active_q;
	logic [ntc_pkg::SUM_W-1:0] sum_q, sum_next;
	logic [ntc_pkg::CNT_W-1:0] cnt_base;
	logic                      busy, in_xfer, go, act_now;
	logic [ntc_pkg::SUM_W-1:0] sum_base;

	assign in_ch.ready = !busy;
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign act_now = active_q || in_ch.start_conversion;
	assign cnt_base = in_ch.start_conversion ? '0 : count_q;
	assign sum_base = in_ch.start_conversion ? '0 : sum_q;
	assign sum_next = (cnt_base >= ntc_pkg::CNT_W'(ntc_pkg::DISCARD_SAMPLES))
		? sum_base + ntc_pkg::SUM_W'(in_ch.sample) : sum_base;
	assign go = in_xfer && act_now
		&& (cnt_base == ntc_pkg::CNT_W'(ntc_pkg::DISCARD_SAMPLES + ntc_pkg::AVG_SAMPLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			active_q <= 1'b0;
			sum_q <= '0;
		end else if (in_xfer && act_now) begin
			sum_q <= sum_next;
			if (go) begin
				count_q <= '0;
				active_q <= 1'b0;
			end else begin
				count_q <= cnt_base + 1'b1;
				active_q <= 1'b1;
			end
		end
	end

	ntc_pkg::dp_cmd_t cmd;
	ntc_pkg::dp_sts_t sts;

	ntc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.out_taken (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.out_valid (out_ch.valid)
	);

	ntc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sum         (sum_next),
		.full_scale  (full_scale_q),
		.series_res  (series_res_q),
		.nominal_res (nominal_res_q),
		.beta        (beta_q),
		.nominal_t   (nominal_t_q),
		.fault_thr   (fault_thr_q),
		.sts         (sts),
		.temp        (out_ch.temperature_centi_c),
		.fault       (out_ch.sensor_fault)
	);

endmodule
